@@ sv/matrix4_inverse_assert.svh @@
// assertion macros for the 4x4 matrix inverter
`ifndef MATRIX4_INVERSE_ASSERT_SVH
`define MATRIX4_INVERSE_ASSERT_SVH

// property: antecedent implies consequent in the same cycle
`define M4INV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("matrix4_inverse assertion failed");

// property: antecedent implies consequent in the next cycle
`define M4INV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("matrix4_inverse assertion failed");

`endif

@@ sv/m4inv_pkg.sv @@
// types, widths and helpers shared by the 4x4 matrix inverter
package m4inv_pkg;

   localparam int ELEM_W = 32;
   localparam int IDX_W  = 4;
   localparam int MUL_W  = 33;
   localparam int PROD_W = 66;
   localparam int MIN_W  = 65;
   localparam int COF_W  = 97;
   localparam int DET_W  = 132;
   localparam int Q_W    = 33;

   localparam logic [ELEM_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [ELEM_W-1:0] SAT_NEG = 32'h8000_0000;

   typedef enum logic [3:0] {
      S_LOAD,
      S_COF,
      S_DET,
      S_DPREP,
      S_DIVINIT,
      S_DIVCHK,
      S_DIV,
      S_FIN,
      S_OUT
   } state_type;

   // address of element (u,v) of the 3x3 submatrix that drops row r and column c
   function automatic logic [3:0] elem_addr(input logic [1:0] r, input logic [1:0] c,
                                            input logic [1:0] u, input logic [1:0] v);
      logic [1:0] row;
      logic [1:0] col;
      row = (u >= r) ? u + 2'd1 : u;
      col = (v >= c) ? v + 2'd1 : v;
      return {row, col};
   endfunction

endpackage

@@ sv/matrix4_inverse.sv @@
// 4x4 fixed-point matrix inverter, cofactor method with a shared multiplier and serial divider
// Takes the 16 elements of a signed Q(31-FRAC_BITS).FRAC_BITS matrix one word per cycle on the
// req_ channel, each tagged with its row-major index; entries persist between runs and every
// entry must have been written before an index 15 word arrives. The index 15 word starts the
// inversion and req_ready stays low until the 16 inverse elements have all been taken on the
// rsp_ channel in row-major order, rsp_last marking the sixteenth. Each result is the exact
// cofactor times 2^(2*FRAC_BITS) divided by the exact determinant, rounded to nearest with ties
// away from zero and saturated to 32 bits; a zero determinant gives zeros with rsp_singular set.
// Sequence: one 33x33 signed multiplier does all products, and a 3x3 cofactor is summed over
// three terms. The determinant adds, for each column of row 0, its cofactor times the row 0
// element in three digits. Each result then takes its cofactor products, divider setup, a
// one-bit-per-cycle restoring divider, a saturation and sign step and the output register, and
// the next result starts only after this one is taken; a quotient that is already known to
// saturate skips the divider. A singular matrix yields one result per cycle after the
// determinant while rsp_ready stays high.
module matrix4_inverse #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [m4inv_pkg::IDX_W-1:0]       req_element_index,
   input  logic signed [m4inv_pkg::ELEM_W-1:0] req_element_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [m4inv_pkg::IDX_W-1:0]       rsp_result_index,
   output logic signed [m4inv_pkg::ELEM_W-1:0] rsp_result_value,
   output logic                              rsp_singular,
   output logic                              rsp_last
);
   import m4inv_pkg::*;

   `include "matrix4_inverse_assert.svh"

   // divider widths follow from the fraction width
   localparam int SH    = 2 * FRAC_BITS + 1;
   localparam int NUM_W = 133 + 2 * FRAC_BITS;
   localparam int REM_W = 134 + 2 * FRAC_BITS;

   state_type state_ff, state_in;

   // stored matrix, written by the input channel
   logic signed [ELEM_W-1:0] mat_ff [16];

   // sequencer counters
   logic [3:0]  k_ff, k_in;          // result index, or column of row 0 while forming det
   logic [1:0]  term_ff, term_in;    // term of the 3x3 expansion
   logic [2:0]  sub_ff, sub_in;      // step within a term or det update
   logic [5:0]  cnt_ff, cnt_in;      // divider bit count
   logic        phase_ff, phase_in;  // 0 while forming det, 1 while producing results
   logic        sing_ff, sing_in;

   // arithmetic registers
   logic signed [ELEM_W-1:0] bop_ff, bop_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [MIN_W-1:0]  minor_ff, minor_in;
   logic signed [COF_W-1:0]  cof_ff, cof_in;
   logic signed [DET_W-1:0]  det_ff, det_in;
   logic [DET_W-1:0]         dabs_ff, dabs_in;
   logic                     dneg_ff, dneg_in;
   logic                     neg_ff, neg_in;
   logic [NUM_W-1:0]         num_ff, num_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [Q_W-1:0]           nlo_ff, nlo_in;
   logic [Q_W-1:0]           q_ff, q_in;
   logic                     ovf_ff, ovf_in;

   // result word
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]         rsp_index_ff, rsp_index_in;
   logic [ELEM_W-1:0]        rsp_value_ff, rsp_value_in;
   logic                     rsp_sing_ff, rsp_sing_in;
   logic                     rsp_last_ff, rsp_last_in;

   // combinational helpers
   logic [1:0]               cur_r, cur_c, v0, v1;
   logic [3:0]               rd_addr;
   logic signed [ELEM_W-1:0] mat_rd;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic                     cof_sub;
   logic signed [COF_W-1:0]  prod_cof;
   logic signed [DET_W-1:0]  prod_det;
   logic [COF_W-1:0]         cabs;
   logic [REM_W-1:0]         dd;
   logic [REM_W-1:0]         trial;
   logic [REM_W-1:0]         rem_top;

   assign req_ready        = (state_ff == S_LOAD);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_singular     = rsp_sing_ff;
   assign rsp_last         = rsp_last_ff;

   // cofactor position: row 0 while forming det, inverse uses the adjugate (transposed cofactors)
   assign cur_r = phase_ff ? k_ff[1:0] : 2'd0;
   assign cur_c = phase_ff ? k_ff[3:2] : k_ff[1:0];

   // minor columns of the submatrix for the current term
   assign v0 = (term_ff == 2'd0) ? 2'd1 : 2'd0;
   assign v1 = (term_ff == 2'd2) ? 2'd1 : 2'd2;

   // odd terms and odd cofactor positions subtract
   assign cof_sub = (term_ff == 2'd1) ^ cur_r[0] ^ cur_c[0];

   assign prod_cof = {{(COF_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign prod_det = {{(DET_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign cabs     = cof_ff[COF_W-1] ? COF_W'(-cof_ff) : COF_W'(cof_ff);
   assign dd       = REM_W'(dabs_ff) << 1;
   assign trial    = {rem_ff[REM_W-2:0], nlo_ff[Q_W-1]};
   assign rem_top  = REM_W'(num_ff[NUM_W-1:Q_W]);

   // single read port on the stored matrix
   always_comb begin
      rd_addr = {2'd0, k_ff[1:0]};
      if (state_ff == S_COF) begin
         case (sub_ff)
            3'd0:    rd_addr = elem_addr(cur_r, cur_c, 2'd2, v1);
            3'd1:    rd_addr = elem_addr(cur_r, cur_c, 2'd1, v0);
            3'd2:    rd_addr = elem_addr(cur_r, cur_c, 2'd2, v0);
            3'd3:    rd_addr = elem_addr(cur_r, cur_c, 2'd1, v1);
            default: rd_addr = elem_addr(cur_r, cur_c, 2'd0, term_ff);
         endcase
      end
   end

   assign mat_rd = mat_ff[rd_addr];

   // shared multiplier operands
   always_comb begin
      mul_a = {mat_rd[ELEM_W-1], mat_rd};
      mul_b = {bop_ff[ELEM_W-1], bop_ff};
      if (state_ff == S_COF) begin
         case (sub_ff)
            3'd5:    mul_b = {1'b0, minor_ff[31:0]};
            3'd6:    mul_b = minor_ff[MIN_W-1:32];
            default: mul_b = {bop_ff[ELEM_W-1], bop_ff};
         endcase
      end else if (state_ff == S_DET) begin
         case (sub_ff)
            3'd0:    mul_b = {1'b0, cof_ff[31:0]};
            3'd1:    mul_b = {1'b0, cof_ff[63:32]};
            default: mul_b = cof_ff[COF_W-1:64];
         endcase
      end
   end

   assign prod_in = mul_a * mul_b;

   // sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      term_in      = term_ff;
      sub_in       = sub_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      sing_in      = sing_ff;
      bop_in       = bop_ff;
      minor_in     = minor_ff;
      cof_in       = cof_ff;
      det_in       = det_ff;
      dabs_in      = dabs_ff;
      dneg_in      = dneg_ff;
      neg_in       = neg_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      nlo_in       = nlo_ff;
      q_in         = q_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_sing_in  = rsp_sing_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         S_LOAD: begin
            if (req_valid && (req_element_index == 4'hF)) begin
               state_in = S_COF;
               phase_in = 1'b0;
               k_in     = '0;
               det_in   = '0;
               cof_in   = '0;
               term_in  = '0;
               sub_in   = '0;
            end
         end

         S_COF: begin
            // minor = a*d - b*c, then cofactor +/- element * minor in two digits
            case (sub_ff)
               3'd0:    bop_in   = mat_rd;
               3'd2: begin
                  minor_in = prod_ff[MIN_W-1:0];
                  bop_in   = mat_rd;
               end
               3'd4:    minor_in = minor_ff - prod_ff[MIN_W-1:0];
               3'd6:    cof_in   = cof_sub ? cof_ff - prod_cof : cof_ff + prod_cof;
               3'd7: begin
                  cof_in = cof_sub ? cof_ff - (prod_cof <<< 32) : cof_ff + (prod_cof <<< 32);
               end
               default: cof_in   = cof_ff;
            endcase
            if (sub_ff == 3'd7) begin
               sub_in = '0;
               if (term_ff == 2'd2) begin
                  term_in  = '0;
                  state_in = phase_ff ? S_DIVINIT : S_DET;
               end else begin
                  term_in = term_ff + 2'd1;
               end
            end else begin
               sub_in = sub_ff + 3'd1;
            end
         end

         S_DET: begin
            // det += m[0][k] * cofactor, cofactor taken in three digits
            case (sub_ff)
               3'd1:    det_in = det_ff + prod_det;
               3'd2:    det_in = det_ff + (prod_det <<< 32);
               3'd3:    det_in = det_ff + (prod_det <<< 64);
               default: det_in = det_ff;
            endcase
            if (sub_ff == 3'd3) begin
               sub_in = '0;
               if (k_ff == 4'd3) begin
                  state_in = S_DPREP;
               end else begin
                  k_in     = k_ff + 4'd1;
                  cof_in   = '0;
                  state_in = S_COF;
               end
            end else begin
               sub_in = sub_ff + 3'd1;
            end
         end

         S_DPREP: begin
            sing_in  = (det_ff == '0);
            dneg_in  = det_ff[DET_W-1];
            dabs_in  = det_ff[DET_W-1] ? DET_W'(-det_ff) : DET_W'(det_ff);
            phase_in = 1'b1;
            k_in     = '0;
            term_in  = '0;
            sub_in   = '0;
            cof_in   = '0;
            if (det_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = '0;
               rsp_value_in = '0;
               rsp_sing_in  = 1'b1;
               rsp_last_in  = 1'b0;
               state_in     = S_OUT;
            end else begin
               state_in = S_COF;
            end
         end

         S_DIVINIT: begin
            // numerator |C|*2^(2F+1) + |D| over 2|D| rounds half away from zero
            num_in   = (NUM_W'(cabs) << SH) + NUM_W'(dabs_ff);
            neg_in   = cof_ff[COF_W-1] ^ dneg_ff;
            state_in = S_DIVCHK;
         end

         S_DIVCHK: begin
            rem_in   = rem_top;
            nlo_in   = num_ff[Q_W-1:0];
            q_in     = '0;
            cnt_in   = '0;
            ovf_in   = (rem_top >= dd);
            state_in = (rem_top >= dd) ? S_FIN : S_DIV;
         end

         S_DIV: begin
            // restoring divide, one quotient bit per cycle
            if (trial >= dd) begin
               rem_in = trial - dd;
               q_in   = {q_ff[Q_W-2:0], 1'b1};
            end else begin
               rem_in = trial;
               q_in   = {q_ff[Q_W-2:0], 1'b0};
            end
            nlo_in = nlo_ff << 1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(Q_W - 1)) begin
               state_in = S_FIN;
            end
         end

         S_FIN: begin
            if (ovf_ff || q_ff[Q_W-1]) begin
               rsp_value_in = neg_ff ? SAT_NEG : SAT_POS;
            end else if (neg_ff) begin
               rsp_value_in = q_ff[31] ? SAT_NEG : ELEM_W'(-q_ff[31:0]);
            end else begin
               rsp_value_in = q_ff[31] ? SAT_POS : q_ff[31:0];
            end
            rsp_valid_in = 1'b1;
            rsp_index_in = k_ff;
            rsp_sing_in  = 1'b0;
            rsp_last_in  = (k_ff == 4'hF);
            state_in     = S_OUT;
         end

         S_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (k_ff == 4'hF) begin
                  state_in = S_LOAD;
               end else begin
                  k_in = k_ff + 4'd1;
                  if (sing_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_index_in = k_ff + 4'd1;
                     rsp_value_in = '0;
                     rsp_sing_in  = 1'b1;
                     rsp_last_in  = (k_ff == 4'hE);
                  end else begin
                     cof_in   = '0;
                     term_in  = '0;
                     sub_in   = '0;
                     state_in = S_COF;
                  end
               end
            end
         end

         default: state_in = S_LOAD;
      endcase
   end

   // element store
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mat_ff[req_element_index] <= req_element_value;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // sequencer and datapath registers
   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      term_ff      <= term_in;
      sub_ff       <= sub_in;
      cnt_ff       <= cnt_in;
      phase_ff     <= phase_in;
      sing_ff      <= sing_in;
      bop_ff       <= bop_in;
      prod_ff      <= prod_in;
      minor_ff     <= minor_in;
      cof_ff       <= cof_in;
      det_ff       <= det_in;
      dabs_ff      <= dabs_in;
      dneg_ff      <= dneg_in;
      neg_ff       <= neg_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      nlo_ff       <= nlo_in;
      q_ff         <= q_in;
      ovf_ff       <= ovf_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sing_ff  <= rsp_sing_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // no result word while elements are being loaded
   `M4INV_ASSERT_NOW(a_load_no_rsp, clock, reset, req_ready, !rsp_valid)
   // singular words carry zero
   `M4INV_ASSERT_NOW(a_sing_zero, clock, reset, rsp_valid && rsp_singular, rsp_result_value == 0)
   // last word is index 15 and hands control back to loading
   `M4INV_ASSERT_NOW(a_last_idx, clock, reset, rsp_valid && rsp_last, rsp_result_index == 4'hF)
   `M4INV_ASSERT_NEXT(a_last_done, clock, reset, rsp_valid && rsp_ready && rsp_last, req_ready)

endmodule

@@ verif/matrix4_inverse_checker.sv @@
// channel monitor, inverse predictor and result scoreboard for the 4x4 matrix inverter
module matrix4_inverse_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [m4inv_pkg::IDX_W-1:0]          req_element_index,
   input  logic signed [m4inv_pkg::ELEM_W-1:0]  req_element_value,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [m4inv_pkg::IDX_W-1:0]          rsp_result_index,
   input  logic signed [m4inv_pkg::ELEM_W-1:0]  rsp_result_value,
   input  logic                                 rsp_singular,
   input  logic                                 rsp_last,
   output int                                   failures,
   output int                                   pending,
   output int                                   words_checked,
   output int                                   singular_words
);
   timeunit 1ns;
   timeprecision 1ps;

   import m4inv_pkg::*;

   localparam int FRAC = 16;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic [IDX_W-1:0]  idx;
      logic [ELEM_W-1:0] value;
      logic              sing;
      logic              last;
   } inverse_word_type;

   logic signed [ELEM_W-1:0] matrix_mirror [16];
   inverse_word_type inverse_queue [$];

   // signed cofactor of element (r,c) of the mirrored matrix
   function automatic wide_type cofactor_of(input int r, input int c);
      wide_type s [9];
      wide_type d;
      int k;
      k = 0;
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            if (i != r && j != c) begin
               s[k] = wide_type'(matrix_mirror[i*4+j]);
               k++;
            end
      d = s[0] * (s[4]*s[8] - s[5]*s[7])
        - s[1] * (s[3]*s[8] - s[5]*s[6])
        + s[2] * (s[3]*s[7] - s[4]*s[6]);
      return ((r + c) % 2 == 1) ? -d : d;
   endfunction

   // cof * 2^(2F) / det, nearest with ties away from zero, saturated
   function automatic logic [31:0] scaled_quotient(input wide_type cof, input wide_type det);
      wide_type n, d, q;
      logic neg;
      neg = (cof < 0) != (det < 0);
      n = (cof < 0) ? -cof : cof;
      d = (det < 0) ? -det : det;
      q = ((n <<< (2*FRAC + 1)) + d) / (d <<< 1);
      if (neg) return (q >= 256'sh8000_0000) ? SAT_NEG : 32'(-q);
      return (q > 256'sh7FFF_FFFF) ? SAT_POS : 32'(q);
   endfunction

   task automatic predict_inverse();
      wide_type det;
      inverse_word_type w;
      det = 0;
      for (int k = 0; k < 4; k++)
         det += wide_type'(matrix_mirror[k]) * cofactor_of(0, k);
      for (int k = 0; k < 16; k++) begin
         w.idx  = 4'(k);
         w.sing = (det == 0);
         w.last = (k == 15);
         // adjugate is the transposed cofactor matrix
         w.value = w.sing ? '0 : scaled_quotient(cofactor_of(k % 4, k / 4), det);
         inverse_queue.push_back(w);
      end
   endtask

   always @(posedge clock) begin
      inverse_word_type e;
      if (reset) begin
         inverse_queue.delete();
      end else begin
         if (req_valid && req_ready) begin
            matrix_mirror[req_element_index] = req_element_value;
            if (req_element_index == 4'd15) predict_inverse();
         end
         if (rsp_valid && rsp_ready) begin
            if (inverse_queue.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("mismatch: unexpected word idx=%0d value=%h", rsp_result_index,
                           rsp_result_value);
            end else begin
               e = inverse_queue.pop_front();
               words_checked++;
               if (rsp_singular) singular_words++;
               if (rsp_result_index !== e.idx || rsp_result_value !== e.value ||
                   rsp_singular !== e.sing || rsp_last !== e.last) begin
                  failures++;
                  if (failures <= 10)
                     $display({"mismatch: exp idx=%0d val=%h sing=%b last=%b, ",
                               "got idx=%0d val=%h sing=%b last=%b"},
                              e.idx, e.value, e.sing, e.last, rsp_result_index,
                              rsp_result_value, rsp_singular, rsp_last);
               end
            end
         end
      end
      pending = inverse_queue.size();
   end

   initial begin
      failures = 0;
      pending = 0;
      words_checked = 0;
      singular_words = 0;
   end

endmodule

@@ verif/tb_matrix4_inverse.sv @@
// top-level testbench for the 4x4 matrix inverter: stimulus, stalls, watchdog and verdict
module tb_matrix4_inverse;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_WORDS   = 480;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [m4inv_pkg::IDX_W-1:0] req_element_index;
   logic signed [m4inv_pkg::ELEM_W-1:0] req_element_value;
   logic rsp_valid;
   logic rsp_ready;
   logic [m4inv_pkg::IDX_W-1:0] rsp_result_index;
   logic signed [m4inv_pkg::ELEM_W-1:0] rsp_result_value;
   logic rsp_singular;
   logic rsp_last;

   int failures, pending, words_checked, singular_words;
   int idle_cycles;
   int words_sent;
   int matrices_sent;
   bit calm;         // no new gaps or stalls start on either side while set
   int stall_left;

   matrix4_inverse dut (.*);

   matrix4_inverse_checker checker_i (.*);

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // element values: small q16.16, full range, or corner values
   function automatic logic [31:0] pick_value(input int style);
      case (style)
         0: return 32'($urandom_range(0, 16 * 65536)) - 32'(8 * 65536);
         1: return $urandom;
         default: begin
            case ($urandom_range(0, 6))
               0: return 32'h0000_0000;
               1: return 32'h0000_0001;
               2: return 32'hFFFF_FFFF;
               3: return 32'h7FFF_FFFF;
               4: return 32'h8000_0000;
               5: return 32'h0001_0000;
               default: return 32'hFFFF_0000;
            endcase
         end
      endcase
   endfunction

   // called at a falling edge; returns at a falling edge with the word taken
   task automatic send_word(input logic [3:0] idx, input logic [31:0] val);
      int g;
      req_valid = 1'b1;
      req_element_index = idx;
      req_element_value = val;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      words_sent++;
      if (idx == 4'd15) matrices_sent++;
      g = gap_len();
      if (g > 0) begin
         req_valid = 1'b0;
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // result side back-pressure, driven at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 3) == 0) stall_left <= gap_len();
      end
   end

   // watchdog on cycles where no word moves on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] vals [16];
      int order [15];
      int kind, style, n, tmp, j, seq;
      reset = 1'b1;
      req_valid = 1'b0;
      req_element_index = '0;
      req_element_value = '0;
      rsp_ready = 1'b0;
      idle_cycles = 0;
      words_sent = 0;
      matrices_sent = 0;
      stall_left = 0;
      calm = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: identity loads every entry before the first inversion
      for (int k = 0; k < 16; k++)
         send_word(4'(k), (k % 5 == 0) ? 32'h0001_0000 : 32'h0);
      calm = 1'b0;
      // most negative element on the diagonal
      send_word(4'd0, m4inv_pkg::SAT_NEG);
      send_word(4'd15, 32'h0001_0000);
      // tiny diagonal entry, inverse saturates positive
      send_word(4'd5, 32'h0000_0001);
      send_word(4'd15, 32'h0001_0000);
      // most positive element on the diagonal
      send_word(4'd10, m4inv_pkg::SAT_POS);
      send_word(4'd15, 32'hFFFF_FFFF);
      // zero last row, singular
      send_word(4'd12, 32'h0);
      send_word(4'd13, 32'h0);
      send_word(4'd14, 32'h0);
      send_word(4'd15, 32'h0);
      wait_drained();

      // random: mostly full reloads in shuffled order, some partial updates and noise
      seq = 0;
      while (words_sent < RANDOM_WORDS + 26) begin
         seq++;
         calm = ($urandom_range(0, 5) == 0);
         kind = $urandom_range(0, 9);
         style = $urandom_range(0, 2);
         if (kind < 7) begin
            for (int k = 0; k < 16; k++)
               vals[k] = pick_value(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : style);
            // duplicated row forces a zero determinant
            if ($urandom_range(0, 6) == 0)
               for (int k = 0; k < 4; k++) vals[8 + k] = vals[k];
            for (int k = 0; k < 15; k++) order[k] = k;
            for (int k = 14; k > 0; k--) begin
               j = $urandom_range(0, k);
               tmp = order[k];
               order[k] = order[j];
               order[j] = tmp;
            end
            for (int k = 0; k < 15; k++) send_word(4'(order[k]), vals[order[k]]);
            send_word(4'd15, vals[15]);
         end else if (kind < 9) begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) send_word(4'($urandom_range(0, 14)), pick_value(style));
            send_word(4'd15, pick_value(style));
         end else begin
            send_word(4'($urandom_range(0, 15)), pick_value(1));
         end
         // every fifth round the sender holds off until all results are back
         if (seq % 5 == 0) wait_drained();
      end

      calm = 1'b0;
      wait_drained();
      repeat (60) @(negedge clock);

      $display("covered %0d words in, %0d inversions, %0d result words checked (%0d singular)",
               words_sent, matrices_sent, words_checked, singular_words);
      if (failures == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
